[sv/icdf_pkg.sv]
// Shared constants and types for the inverse CDF sampler.
package icdf_pkg;

  localparam int unsigned DEPTH_DEF = 4096;
  localparam int unsigned PROB_W    = 33;
  localparam int unsigned ENERGY_W  = 32;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned COUNT_W   = 13;
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned FRAC_W    = 17;   // Q1.16 fraction, 0..65536
  localparam int unsigned REG_IDX_W = 2;

  localparam logic [PROB_W-1:0] ONE_Q32 = 33'h1_0000_0000;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_E_MIN       = 2'd0,
    REG_E_MAX       = 2'd1,
    REG_E_STEP      = 2'd2,
    REG_ENTRY_COUNT = 2'd3
  } reg_idx_t;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

endpackage

[sv/icdf_div.sv]
// Restoring divider: quotient of (num << (QUOT_W-1)) / den, one bit per cycle.
module icdf_div
  import icdf_pkg::*;
#(
  parameter int unsigned NUM_W  = PROB_W,
  parameter int unsigned QUOT_W = FRAC_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [NUM_W-1:0]  den,
  output logic              done,
  output logic [QUOT_W-1:0] quot
);

  localparam int unsigned REM_W = NUM_W + 2;
  localparam int unsigned CNT_W = $clog2(QUOT_W + 1);

  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] den_r;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             ge;
  logic [REM_W-1:0] rem_sub;

  // num <= den is assumed, so the remainder stays below 2*den
  assign ge      = rem >= den_r;
  assign rem_sub = ge ? rem - den_r : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUOT_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= REM_W'(num);
      den_r <= REM_W'(den);
      quot  <= '0;
    end else if (busy) begin
      rem  <= {rem_sub[REM_W-2:0], 1'b0};
      quot <= {quot[QUOT_W-2:0], ge};
    end
  end

endmodule

[sv/inverse_cdf_sampler.sv]
// Inverse transform sampler: CDF table memory, linear scan, interpolation.
// Table write or out-of-range probability: straight from idle to the output state.
// Sample, n = entries in use: the scan reads up to n table entries, one entry
// per cycle from the single-port memory, then the divider, multiply, add.
// One item is in work at a time; a new item is taken while a result waits out.
// Synchronous reset clears control and config registers; datapath and table are not cleared.
module inverse_cdf_sampler
  import icdf_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // config
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // items in
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 cmd,
  input  logic [IDX_W-1:0]     entry_index,
  input  logic [PROB_W-1:0]    entry_value,
  input  logic [PROB_W-1:0]    prob,
  // results out
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ENERGY_W-1:0]  energy,
  output logic                 status
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_PICK = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_SUM  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state;

  logic [ENERGY_W-1:0] e_min;
  logic [ENERGY_W-1:0] e_max;
  logic [ENERGY_W-1:0] e_step;
  logic [COUNT_W-1:0]  entry_count;

  logic [PROB_W-1:0] mem [TABLE_DEPTH];
  logic [PROB_W-1:0] mem_q;

  logic              in_xfer;
  logic [NW-1:0]     n;
  logic [NW-1:0]     ra;
  logic [NW-1:0]     ri;
  logic              rd_pending;
  logic              rd_en;
  logic              hit;
  logic [31:0]       widx;
  logic              wr_en;

  logic [PROB_W-1:0] p_reg;
  logic [PROB_W-1:0] prev_val;
  logic [PROB_W-1:0] lo;
  logic [PROB_W-1:0] hi;
  logic [NW-1:0]     fidx;

  logic              div_start;
  logic              div_done;
  logic [FRAC_W-1:0] div_quot;
  logic [FRAC_W-1:0] frac;
  logic [31:0]       pos;
  logic [63:0]       prod;
  logic [48:0]       sum;

  logic [ENERGY_W-1:0] res_energy;
  logic                res_status;

  assign cfg_ready = 1'b1;
  assign in_stall  = state != S_IDLE;
  assign in_xfer   = in_valid && !in_stall;

  assign n = (32'(entry_count) > 32'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : NW'(entry_count);

  assign widx  = 32'(entry_index);
  assign wr_en = in_xfer && cmd == CMD_WRITE && widx < 32'(TABLE_DEPTH);

  assign hit   = rd_pending && p_reg <= mem_q;
  assign rd_en = state == S_SCAN && ra < n && !hit;

  assign div_start = state == S_PICK && fidx != '0
                     && ({1'b0, fidx} + 1'b1) < {1'b0, n};

  assign pos = ((32'(fidx) - 32'd1) << 16) + 32'(frac);
  assign sum = 49'(e_min) + 49'(prod[63:16]);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      e_min       <= '0;
      e_max       <= '0;
      e_step      <= '0;
      entry_count <= COUNT_W'(4096);
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_E_MIN:       e_min       <= cfg_data;
        REG_E_MAX:       e_max       <= cfg_data;
        REG_E_STEP:      e_step      <= cfg_data;
        REG_ENTRY_COUNT: entry_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // table memory, one write or one read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[widx[AW-1:0]] <= entry_value;
    end
    if (rd_en) begin
      mem_q <= mem[ra[AW-1:0]];
    end
  end

  icdf_div #(
    .NUM_W  (PROB_W),
    .QUOT_W (FRAC_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (p_reg - lo),
    .den   (hi - lo),
    .done  (div_done),
    .quot  (div_quot)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      rd_pending <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (cmd == CMD_WRITE) begin
              state <= S_OUT;
            end else if (prob > ONE_Q32) begin
              state <= S_OUT;
            end else begin
              state      <= S_SCAN;
              rd_pending <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            state      <= S_PICK;
            rd_pending <= 1'b0;
          end else if (!rd_pending && !(ra < n)) begin
            state <= S_PICK;
          end else begin
            rd_pending <= rd_en;
          end
        end
        S_PICK: begin
          if (div_start) begin
            state <= S_DIV;
          end else begin
            state <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_SUM;
        S_SUM: state <= S_OUT;
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        ra         <= '0;
        p_reg      <= prob;
        res_energy <= '0;
        res_status <= (cmd == CMD_SAMPLE && prob > ONE_Q32) ? STATUS_RANGE : STATUS_OK;
      end
      S_SCAN: begin
        if (hit) begin
          fidx <= ri;
          hi   <= mem_q;
          lo   <= prev_val;
        end else begin
          if (rd_pending) begin
            prev_val <= mem_q;
          end
          if (!rd_pending && !(ra < n)) begin
            fidx <= n;   // no entry matched
          end
        end
        if (rd_en) begin
          ri <= ra;
          ra <= ra + 1'b1;
        end
      end
      S_PICK: begin
        res_energy <= (fidx == '0) ? e_min : e_max;
        res_status <= STATUS_OK;
      end
      S_DIV: begin
        if (div_done) begin
          frac <= div_quot;
        end
      end
      S_MUL: prod <= 64'(pos) * 64'(e_step);
      S_SUM: res_energy <= (sum > 49'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : sum[31:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || !out_stall)) begin
      energy <= res_energy;
      status <= res_status;
    end
  end

endmodule

[sv/icdf_checker.sv]
// Port-level checks for the inverse CDF sampler, bound to the top level.
module icdf_checker
  import icdf_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [ENERGY_W-1:0] energy,
  input logic                status
);

  // a result held back stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // range errors carry no energy
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_RANGE |-> energy == '0)
    else $error("error result with nonzero energy");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transfer while item in work");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind inverse_cdf_sampler icdf_checker u_icdf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .energy    (energy),
  .status    (status)
);

[verif/testbench.sv]
// Self-checking testbench for inverse_cdf_sampler: random traffic, scoreboard, stall bursts.
import icdf_pkg::*;

typedef struct packed {
  logic [ENERGY_W-1:0] energy;
  logic                status;
} energy_result_t;

class sampler_scoreboard;
  logic [PROB_W-1:0]   cdf [DEPTH_DEF];
  logic [ENERGY_W-1:0] e_lo;
  logic [ENERGY_W-1:0] e_hi;
  logic [ENERGY_W-1:0] e_bin;
  logic [COUNT_W-1:0]  used;
  energy_result_t      pending_energy [$];
  int                  errors;

  function new();
    foreach (cdf[k]) cdf[k] = '0;
    e_lo   = '0;
    e_hi   = '0;
    e_bin  = '0;
    used   = DEPTH_DEF;
    errors = 0;
  endfunction

  function void set_reg(reg_idx_t r, logic [CFG_W-1:0] d);
    case (r)
      REG_E_MIN:       e_lo = d;
      REG_E_MAX:       e_hi = d;
      REG_E_STEP:      e_bin = d;
      REG_ENTRY_COUNT: used = d[COUNT_W-1:0];
      default: ;
    endcase
  endfunction

  // Works out the energy/status an accepted item must produce.
  function void predict_energy(logic op, logic [IDX_W-1:0] slot, logic [PROB_W-1:0] val,
                               logic [PROB_W-1:0] p);
    energy_result_t r;
    int unsigned    n;
    int unsigned    i;
    logic [63:0]    num;
    logic [63:0]    den;
    logic [63:0]    pos;
    logic [63:0]    sum;
    r.energy = '0;
    r.status = STATUS_OK;
    if (op == CMD_WRITE) begin
      cdf[slot] = val;
    end else if (p > ONE_Q32) begin
      r.status = STATUS_RANGE;
    end else begin
      n = (used > DEPTH_DEF) ? DEPTH_DEF : used;
      i = 0;
      while (i < n && p > cdf[i]) i++;
      if (i == 0) begin
        r.energy = e_lo;
      end else if (i + 1 >= n) begin
        r.energy = e_hi;
      end else begin
        // lo < p <= hi here, so the divisor is never zero
        num = p - cdf[i-1];
        den = cdf[i] - cdf[i-1];
        pos = 64'(i - 1) * 65536 + (num << 16) / den;
        sum = 64'(e_lo) + ((pos * e_bin) >> 16);
        r.energy = (sum > 64'hFFFF_FFFF) ? '1 : sum[31:0];
      end
    end
    pending_energy.push_back(r);
  endfunction

  function void check_energy(logic [ENERGY_W-1:0] e, logic s, longint unsigned stamp);
    energy_result_t want;
    if (pending_energy.size() == 0) begin
      errors++;
      $display("%0d ns: result with nothing expected: energy %h status %0d", stamp, e, s);
      return;
    end
    want = pending_energy.pop_front();
    if (e !== want.energy) begin
      errors++;
      $display("%0d ns: energy mismatch: expected %h, actual %h", stamp, want.energy, e);
    end
    if (s !== want.status) begin
      errors++;
      $display("%0d ns: status mismatch: expected %0d, actual %0d", stamp, want.status, s);
    end
  endfunction
endclass

module testbench;
  import icdf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD = 10;
  localparam int unsigned LIMIT      = 1_500_000;
  localparam int unsigned HOLD_CYC   = 400;
  localparam int unsigned RAND_ITEMS = 600;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = REG_E_MIN;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 cmd = CMD_WRITE;
  logic [IDX_W-1:0]     entry_index = '0;
  logic [PROB_W-1:0]    entry_value = '0;
  logic [PROB_W-1:0]    prob = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ENERGY_W-1:0]  energy;
  logic                 status;

  sampler_scoreboard sb = new;
  bit                quiet = 1'b0;
  bit                tx_gaps = 1'b1;
  bit                hold_req = 1'b0;
  int unsigned       cycle_count = 0;

  inverse_cdf_sampler DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .prob        (prob),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .energy      (energy),
    .status      (status)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_energy(energy, status, $time);
  end

  // Receiver: stall bursts, free-running stretches, one long hold-off on request.
  initial begin : rx_side
    int unsigned run;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYC) @(posedge clk);
      end else if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            out_stall <= 1'b1;
            run = $urandom_range(1, 16);
          end
          9: begin
            out_stall <= 1'b0;
            run = 64;
          end
          default: begin
            out_stall <= 1'b0;
            run = $urandom_range(1, 16);
          end
        endcase
        repeat (run) @(posedge clk);
      end
    end
  end

  function automatic logic [PROB_W-1:0] rand33();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[PROB_W-1:0];
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 32'h0010_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic op, input logic [IDX_W-1:0] slot,
                           input logic [PROB_W-1:0] val, input logic [PROB_W-1:0] pr);
    if (!quiet && tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= op;
    entry_index <= slot;
    entry_value <= val;
    prob        <= pr;
    do @(posedge clk); while (in_stall);
    sb.predict_energy(op, slot, val, pr);
  endtask

  task automatic send_sample(input logic [PROB_W-1:0] pr);
    send_item(CMD_SAMPLE, $urandom_range(0, DEPTH_DEF - 1), rand33(), pr);
  endtask

  // Drop valid and wait until every expected result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_energy.size() != 0) @(posedge clk);
  endtask

  // Writes all four registers back to back; valid stays up across transfers.
  task automatic load_config(input logic [31:0] lo, input logic [31:0] hi,
                             input logic [31:0] stepw, input logic [COUNT_W-1:0] cnt);
    reg_idx_t         regs [4] = '{REG_E_MIN, REG_E_MAX, REG_E_STEP, REG_ENTRY_COUNT};
    logic [CFG_W-1:0] vals [4];
    vals = '{lo, hi, stepw, {{(CFG_W - COUNT_W){1'b0}}, cnt}};
    for (int r = 0; r < 4; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[r];
      cfg_data  <= vals[r];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(regs[r], vals[r]);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [PROB_W-1:0] pr;
    logic [PROB_W-1:0] lo_b;
    logic [PROB_W-1:0] hi_b;
    logic [PROB_W-1:0] acc;
    int unsigned       n;
    int unsigned       cnt;
    int unsigned       items;
    int unsigned       k;
    int unsigned       j;
    int unsigned       r;
    int unsigned       span;
    int unsigned       sent;
    int unsigned       phase;
    int unsigned       big_phases;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // linear ramp over the whole table so no read ever hits an unwritten entry
    for (k = 0; k < DEPTH_DEF; k++) send_item(CMD_WRITE, k, PROB_W'(k + 1) << 20, rand33());

    drain();
    load_config(32'h0001_0000, 32'h00FF_0000, 32'h0000_8000, 13'd4096);
    send_sample('0);
    send_sample(ONE_Q32);
    send_sample(ONE_Q32 + 1);
    send_sample('1);
    send_sample((PROB_W'(1) << 20) + 1);
    send_sample((PROB_W'(1234) << 20) + 33'h5_4321);
    send_item(CMD_WRITE, '1, '1, rand33());
    send_item(CMD_WRITE, '0, '0, rand33());
    send_sample((PROB_W'(4095) << 20) + 1);

    // interpolated sum past the top of the range saturates
    drain();
    load_config(32'hFFFF_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'd3);
    send_sample(33'd1);
    send_sample(PROB_W'(2) << 20);
    send_sample(PROB_W'(3) << 20);
    send_sample((PROB_W'(3) << 20) + 1);

    drain();
    load_config('0, '1, '0, 13'd0);
    send_sample(33'd12345);

    drain();
    load_config(32'h1234_5678, 32'h8765_4321, 32'h0000_0100, 13'd1);
    send_sample('0);
    send_sample(33'd1);

    // count above the table depth clamps to the full table
    drain();
    load_config('0, 32'hABCD_0000, 32'h0001_0000, 13'd8191);
    send_sample((PROB_W'(100) << 20) + (PROB_W'(1) << 19));

    drain();
    load_config(32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 13'd2);
    send_sample('0);
    send_sample((PROB_W'(1) << 20) + 1);

    sent = 0;
    phase = 0;
    big_phases = 0;
    while (sent < RAND_ITEMS) begin
      drain();
      if (sent >= RAND_ITEMS - 60) quiet = 1'b1;
      r = $urandom_range(0, 19);
      if (r == 15 && big_phases < 3) cnt = DEPTH_DEF;
      else if (r == 16 && big_phases < 3) cnt = $urandom_range(DEPTH_DEF + 1, 8191);
      else if (r == 17) cnt = $urandom_range(0, 1);
      else if (r == 18) cnt = 3;
      else cnt = $urandom_range(2, 40);
      n = (cnt > DEPTH_DEF) ? DEPTH_DEF : cnt;
      load_config(pick_word(), pick_word(), pick_word(), cnt);
      tx_gaps = ($urandom_range(0, 3) != 0);
      if (phase == 3) hold_req = 1'b1;

      if (n < DEPTH_DEF) begin
        // fresh monotonic table for the entries in use, flat spots included
        acc = $urandom_range(0, 4096);
        span = 32'hFFFF_FFFF / (n + 1);
        for (k = 0; k < n; k++) begin
          if (k == n - 1 && acc <= ONE_Q32 && $urandom_range(0, 1) == 1) acc = ONE_Q32;
          send_item(CMD_WRITE, k, acc, rand33());
          sent++;
          if ($urandom_range(0, 7) != 0) acc += $urandom_range(0, span);
        end
        items = $urandom_range(20, 60);
      end else begin
        big_phases++;
        items = 4;
      end

      for (k = 0; k < items; k++) begin
        r = $urandom_range(0, 19);
        if (r < 13 && n > 0) begin
          j = $urandom_range(0, n - 1);
          hi_b = sb.cdf[j];
          lo_b = (j == 0) ? '0 : sb.cdf[j-1];
          case ($urandom_range(0, 2))
            0: pr = hi_b;
            1: pr = lo_b + 1;
            default: pr = (hi_b > lo_b) ? lo_b + 1 + ({$urandom, $urandom} % (hi_b - lo_b))
                                        : hi_b;
          endcase
          send_sample(pr);
        end else if (r < 16) begin
          send_sample(rand33());
        end else if (r == 16) begin
          send_sample(($urandom_range(0, 1) == 1) ? ONE_Q32 : '0);
        end else begin
          send_item(CMD_WRITE,
                    (n > 0 && $urandom_range(0, 1) == 1) ? $urandom_range(0, n - 1)
                                                        : $urandom_range(0, DEPTH_DEF - 1),
                    rand33(), rand33());
        end
        sent++;
      end
      phase++;
    end

    drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/icdf_pkg.sv
sv/icdf_div.sv
sv/inverse_cdf_sampler.sv
sv/icdf_checker.sv
verif/testbench.sv
